// ===== rtl/core/oamc_pkg.sv =====
// Shared types, codes and constants of the obstacle avoid motor controller.
package oamc_pkg;

  localparam int NUM_MOTORS = 2;

  localparam int DIST_W = 12;
  localparam int TIME_W = 32;
  localparam int MS_W   = 16;
  localparam int DUTY_W = 8;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_MS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WALKING_MS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY   = 8'd3;

  localparam logic [DIST_W-1:0] NEAR_LIMIT_RST = 12'd20;
  localparam logic [MS_W-1:0]   BLOCKED_RST    = 16'd1000;
  localparam logic [MS_W-1:0]   WALKING_RST    = 16'd1000;
  localparam logic [DUTY_W-1:0] MAX_DUTY_RST   = 8'd255;

  // Action selector; other codes are never produced and drive a stop.
  typedef enum logic [2:0] {
    ACT_STOP    = 3'd0,
    ACT_FORWARD = 3'd1,
    ACT_VEER_L  = 3'd4,
    ACT_VEER_R  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    PCT_0   = 2'd0,
    PCT_60  = 2'd1,
    PCT_100 = 2'd2
  } pct_t;

  typedef struct packed {
    logic [DIST_W-1:0] near_limit;
    logic [MS_W-1:0]   blocked_ms;
    logic [MS_W-1:0]   walking_ms;
    logic [DUTY_W-1:0] max_duty;
  } cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [TIME_W-1:0] now_ms;
    logic              side_pick;
  } item_t;

  typedef struct packed {
    logic              fwd_pin;
    logic              rev_pin;
    logic [DUTY_W-1:0] duty;
  } motor_t;

  typedef struct packed {
    motor_t right;
    motor_t left;
    logic   avoiding;
  } result_t;

  // Speed of one motor (0 left, 1 right) for an action.
  function automatic pct_t motor_pct(input action_t act, input logic motor);
    pct_t p;
    p = PCT_0;
    case (act)
      ACT_FORWARD: p = PCT_100;
      ACT_VEER_L:  p = motor ? PCT_100 : PCT_60;
      ACT_VEER_R:  p = motor ? PCT_60 : PCT_100;
      default:     p = PCT_0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/oamc_cfg.sv =====
// Configuration register file of the obstacle avoid motor controller.
module oamc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [oamc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [oamc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output oamc_pkg::cfg_t                    cfg
);
  import oamc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_limit <= NEAR_LIMIT_RST;
      cfg.blocked_ms <= BLOCKED_RST;
      cfg.walking_ms <= WALKING_RST;
      cfg.max_duty   <= MAX_DUTY_RST;
    end else if (cfg_valid) begin
      // Drop writes to indexes beyond the register list.
      case (cfg_index)
        CFG_NEAR_LIMIT: cfg.near_limit <= cfg_data[DIST_W-1:0];
        CFG_BLOCKED_MS: cfg.blocked_ms <= cfg_data[MS_W-1:0];
        CFG_WALKING_MS: cfg.walking_ms <= cfg_data[MS_W-1:0];
        CFG_MAX_DUTY:   cfg.max_duty   <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/oamc_ctrl.sv =====
// Avoidance sequencer and motor drive decode for one item a cycle while fire is high.
module oamc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  oamc_pkg::cfg_t      cfg,
  input  logic                fire,
  input  oamc_pkg::item_t     item,
  output oamc_pkg::result_t   result
);
  import oamc_pkg::*;

  logic              avoid_active, avoid_active_next;
  logic [TIME_W-1:0] start_time, start_time_next;
  logic              reverse_dir, reverse_dir_next;
  logic              veer_side, veer_side_next;
  action_t           action_sel, action_sel_next;

  logic              start;
  logic [TIME_W-1:0] elapsed;
  logic [MS_W:0]     t2;
  logic [MS_W+1:0]   t3;
  logic [9:0]        triple;
  logic [17:0]       scaled;
  logic [DUTY_W-1:0] duty60;

  assign t2 = {1'b0, cfg.blocked_ms} + {1'b0, cfg.walking_ms};
  assign t3 = {1'b0, cfg.blocked_ms, 1'b0} + {2'b00, cfg.walking_ms};

  always_comb begin
    start             = (item.distance <= cfg.near_limit) && !avoid_active;
    avoid_active_next = avoid_active | start;
    start_time_next   = start ? item.now_ms : start_time;
    veer_side_next    = start ? item.side_pick : veer_side;
    reverse_dir_next  = start ? 1'b1 : reverse_dir;
    action_sel_next   = start ? ACT_STOP : action_sel;
    elapsed           = item.now_ms - start_time_next;
    if (avoid_active_next && (elapsed >= {16'd0, cfg.blocked_ms})) begin
      action_sel_next = veer_side_next ? ACT_VEER_R : ACT_VEER_L;
      if (elapsed >= {15'd0, t2}) begin
        action_sel_next = ACT_STOP;
        if (elapsed >= {14'd0, t3}) begin
          action_sel_next   = ACT_FORWARD;
          reverse_dir_next  = 1'b0;
          avoid_active_next = 1'b0;
        end
      end
    end
  end

  // 60 percent of max_duty: floor(3m/5) as (3m * 205) >> 10, exact below 1024.
  assign triple = {2'b00, cfg.max_duty} + {1'b0, cfg.max_duty, 1'b0};
  assign scaled = {8'd0, triple} * 18'd205;
  assign duty60 = scaled[17:10];

  function automatic motor_t drive(input pct_t p, input logic rev,
                                   input logic [DUTY_W-1:0] full,
                                   input logic [DUTY_W-1:0] part);
    motor_t m;
    m.fwd_pin = (p != PCT_0) && !rev;
    m.rev_pin = (p != PCT_0) && rev;
    case (p)
      PCT_100: m.duty = full;
      PCT_60:  m.duty = part;
      default: m.duty = '0;
    endcase
    return m;
  endfunction

  always_comb begin
    result.left     = drive(motor_pct(action_sel_next, 1'b0), reverse_dir_next,
                            cfg.max_duty, duty60);
    result.right    = drive(motor_pct(action_sel_next, 1'b1), reverse_dir_next,
                            cfg.max_duty, duty60);
    result.avoiding = avoid_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avoid_active <= 1'b0;
      reverse_dir  <= 1'b0;
      veer_side    <= 1'b0;
      action_sel   <= ACT_FORWARD;
    end else if (fire) begin
      avoid_active <= avoid_active_next;
      reverse_dir  <= reverse_dir_next;
      veer_side    <= veer_side_next;
      action_sel   <= action_sel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      start_time <= start_time_next;
    end
  end

endmodule

// ===== rtl/core/obstacle_avoid_motor_controller_unit.sv =====
// Top level of the obstacle avoid motor controller: input and result registers.
//
//   channel  | direction | handshake                     | payload
//   s_axis   | in        | s_axis_tvalid / s_axis_tready | distance, now_ms, side_pick
//   m_axis   | out       | m_axis_tvalid / m_axis_tready | pin levels, duties, avoiding
//   cfg      | in        | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One item per cycle while m_axis is not stalled; an item taken into the input
// register passes through the sequencer and duty decode into the result register,
// from which it is offered on m_axis.
// Reset clears the sequencer to forward drive and loads register defaults.
// A stall on m_axis holds both stages; s_axis keeps taking items while the
// input register is empty or moving.
module obstacle_avoid_motor_controller_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [11:0] distance, [43:12] now_ms, [44] side_pick, [47:45] zero
  input  logic [oamc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] left_fwd_pin, [1] left_rev_pin, [9:2] left_duty, [10] right_fwd_pin,
  // [11] right_rev_pin, [19:12] right_duty, [20] avoiding, [23:21] zero
  output logic [oamc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [oamc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [oamc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import oamc_pkg::*;

  cfg_t    cfg;
  logic    in_valid;
  item_t   in_item;
  result_t result;
  result_t out_item;
  logic    advance;
  logic    fire;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign fire          = in_valid && advance;

  oamc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  oamc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        m_axis_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.distance  <= s_axis_tdata[11:0];
      in_item.now_ms    <= s_axis_tdata[43:12];
      in_item.side_pick <= s_axis_tdata[44];
    end
    if (fire) begin
      out_item <= result;
    end
  end

  assign m_axis_tdata = {3'b000, out_item.avoiding,
                         out_item.right.duty, out_item.right.rev_pin,
                         out_item.right.fwd_pin,
                         out_item.left.duty, out_item.left.rev_pin,
                         out_item.left.fwd_pin};

endmodule
